// ===== sv/trs_pkg.sv =====
package trs_pkg;

    // action codes carried in s_tuser
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_EFFECT  = 2'd2;
    localparam logic [1:0] ACT_ROW_END = 2'd3;

    // global effect kinds
    localparam logic [2:0] EFF_NONE  = 3'd0;
    localparam logic [2:0] EFF_SPEED = 3'd1;
    localparam logic [2:0] EFF_JUMP  = 3'd2;
    localparam logic [2:0] EFF_SKIP  = 3'd3;
    localparam logic [2:0] EFF_HALT  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_SONG_TEMPO  = 3'd0;
    localparam logic [2:0] CFG_SONG_SPEED  = 3'd1;
    localparam logic [2:0] CFG_FRAME_RATE  = 3'd2;
    localparam logic [2:0] CFG_ROWS        = 3'd3;
    localparam logic [2:0] CFG_FRAMES      = 3'd4;
    localparam logic [2:0] CFG_SPEED_SPLIT = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 40;

    localparam int MAX_FRAMES = 256;
    localparam int MAX_ROWS   = 256;

    localparam int DIVIDEND_W = 13;
    localparam int DIVISOR_W  = 9;

    localparam logic [7:0] RST_SONG_TEMPO  = 8'd150;
    localparam logic [7:0] RST_SONG_SPEED  = 8'd6;
    localparam logic [7:0] RST_FRAME_RATE  = 8'd60;
    localparam logic [8:0] RST_ROWS        = 9'd64;
    localparam logic [8:0] RST_FRAMES      = 9'd1;
    localparam logic [7:0] RST_SPEED_SPLIT = 8'd32;

    typedef enum logic [1:0] {
        DIV_FMOD_START,
        DIV_RMOD_START,
        DIV_DEC,
        DIV_JUMP
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     exec;
        logic     div_start;
        logic     div_wb;
        logic     out_load;
        div_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] kind;
        logic       row_open;
        logic       frame_jump_seen;
        logic       goto_same;
        logic       div_done;
        logic       out_free;
    } stat_t;

    // zero counts as one, anything above the maximum as the maximum
    function automatic logic [8:0] count_of(input logic [8:0] cnt, input logic [8:0] maxv);
        logic [8:0] r;
        if (cnt == 9'd0) begin
            r = 9'd1;
        end else if (cnt > maxv) begin
            r = maxv;
        end else begin
            r = cnt;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7fff;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/trs_div.sv =====
module trs_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [trs_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [trs_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [trs_pkg::DIVIDEND_W-1:0] quotient,
    output logic [trs_pkg::DIVISOR_W-1:0]  remainder
);
    import trs_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic                  ge;

    // one restoring step per cycle, dividend shifted in from the top
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/trs_dp.sv =====
module trs_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [trs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [trs_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [trs_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [trs_pkg::S_USER_W-1:0]   s_tuser,
    input  trs_pkg::cmd_t                   cmd,
    output trs_pkg::stat_t                  stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [trs_pkg::M_DATA_W-1:0]   m_tdata
);
    import trs_pkg::*;

    // configuration
    logic [7:0] song_tempo_reg, song_speed_reg, frame_rate_reg, split_reg;
    logic [8:0] rows_cfg_reg, frames_cfg_reg;

    // latched item
    logic [1:0] act_reg, act_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] val_reg, val_next;
    logic [7:0] sf_reg, sf_next;
    logic [7:0] sr_reg, sr_next;

    // song position state
    logic [15:0] acc_reg, acc_next;
    logic [12:0] dec_reg, dec_next;
    logic [7:0]  tempo_reg, tempo_next;
    logic [7:0]  speed_reg, speed_next;
    logic [7:0]  frame_now_reg, frame_now_next;
    logic [7:0]  row_now_reg, row_now_next;
    logic [7:0]  frame_nxt_reg, frame_nxt_next;
    logic [7:0]  row_nxt_reg, row_nxt_next;
    logic        halt_reg, halt_next;
    logic        js_reg, js_next;
    logic        fjs_reg, fjs_next;
    logic        open_reg, open_next;
    logic        begin_reg, begin_next;

    logic                  mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0]   mdata_reg, mdata_next;

    logic [8:0]  fcount, rcount;
    logic [8:0]  target;
    logic [13:0] rate_x60;
    logic [17:0] acc_ext;
    logic [7:0]  eff_val;
    logic [8:0]  row_inc, frame_inc;

    logic [DIVIDEND_W-1:0] div_dividend, div_quo;
    logic [DIVISOR_W-1:0]  div_divisor, div_rem;
    logic                  div_done;

    assign fcount   = count_of(frames_cfg_reg, 9'(MAX_FRAMES));
    assign rcount   = count_of(rows_cfg_reg, 9'(MAX_ROWS));
    assign target   = (kind_reg == EFF_JUMP) ? {1'b0, val_reg} : {1'b0, frame_now_reg} + 9'd1;
    assign rate_x60 = {frame_rate_reg, 6'd0} - {4'd0, frame_rate_reg, 2'd0};
    assign acc_ext  = {{2{acc_reg[15]}}, acc_reg};
    assign eff_val  = (val_reg == 8'd0) ? 8'd1 : val_reg;
    assign row_inc  = {1'b0, row_nxt_reg} + 9'd1;
    assign frame_inc = {1'b0, frame_nxt_reg} + 9'd1;

    always_comb begin
        unique case (cmd.sel)
            DIV_FMOD_START: begin
                div_dividend = {5'd0, sf_reg};
                div_divisor  = fcount;
            end
            DIV_RMOD_START: begin
                div_dividend = {5'd0, sr_reg};
                div_divisor  = rcount;
            end
            DIV_DEC: begin
                // tempo * 24
                div_dividend = {1'b0, tempo_reg, 4'd0} + {2'd0, tempo_reg, 3'd0};
                div_divisor  = {1'b0, speed_reg};
            end
            DIV_JUMP: begin
                div_dividend = {4'd0, target};
                div_divisor  = fcount;
            end
        endcase
    end

    trs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        act_next       = act_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        sf_next        = sf_reg;
        sr_next        = sr_reg;
        acc_next       = acc_reg;
        dec_next       = dec_reg;
        tempo_next     = tempo_reg;
        speed_next     = speed_reg;
        frame_now_next = frame_now_reg;
        row_now_next   = row_now_reg;
        frame_nxt_next = frame_nxt_reg;
        row_nxt_next   = row_nxt_reg;
        halt_next      = halt_reg;
        js_next        = js_reg;
        fjs_next       = fjs_reg;
        open_next      = open_reg;
        begin_next     = begin_reg;

        if (cmd.load) begin
            act_next   = s_tuser;
            kind_next  = s_tdata[2:0];
            val_next   = s_tdata[10:3];
            sf_next    = s_tdata[18:11];
            sr_next    = s_tdata[26:19];
            begin_next = 1'b0;
        end

        if (cmd.exec) begin
            unique case (act_reg)
                ACT_TICK: begin
                    if (!halt_reg && !open_reg) begin
                        if (acc_reg[15] || acc_reg == 16'd0) begin
                            acc_next       = sat16(acc_ext + {4'd0, rate_x60});
                            js_next        = 1'b0;
                            fjs_next       = 1'b0;
                            frame_now_next = frame_nxt_reg;
                            row_now_next   = row_nxt_reg;
                            open_next      = 1'b1;
                            begin_next     = 1'b1;
                        end else begin
                            acc_next = sat16(acc_ext - {5'd0, dec_reg});
                        end
                    end
                end
                ACT_START: begin
                    tempo_next = (song_tempo_reg == 8'd0) ? 8'd1 : song_tempo_reg;
                    speed_next = (song_speed_reg == 8'd0) ? 8'd1 : song_speed_reg;
                    acc_next   = '0;
                    halt_next  = 1'b0;
                    js_next    = 1'b0;
                    fjs_next   = 1'b0;
                    open_next  = 1'b0;
                end
                ACT_EFFECT: begin
                    if (open_reg) begin
                        unique case (kind_reg)
                            EFF_SPEED: begin
                                if (eff_val > split_reg) begin
                                    tempo_next = eff_val;
                                end else begin
                                    speed_next = eff_val;
                                end
                            end
                            EFF_JUMP: fjs_next = 1'b1;
                            EFF_SKIP: begin
                                if (!fjs_reg) begin
                                    row_nxt_next = val_reg;
                                end
                            end
                            EFF_HALT: halt_next = 1'b1;
                            default: ;
                        endcase
                    end
                end
                ACT_ROW_END: begin
                    if (open_reg) begin
                        open_next = 1'b0;
                        if (!js_reg) begin
                            if (row_inc >= rcount) begin
                                row_nxt_next   = 8'd0;
                                frame_nxt_next = (frame_inc >= fcount) ? 8'd0 : frame_inc[7:0];
                            end else begin
                                row_nxt_next = row_inc[7:0];
                            end
                        end
                        acc_next = sat16(acc_ext - {5'd0, dec_reg});
                    end
                end
            endcase
        end

        if (cmd.div_wb) begin
            unique case (cmd.sel)
                DIV_FMOD_START: begin
                    frame_now_next = div_rem[7:0];
                    frame_nxt_next = div_rem[7:0];
                end
                DIV_RMOD_START: begin
                    row_now_next = div_rem[7:0];
                    row_nxt_next = div_rem[7:0];
                end
                DIV_DEC: dec_next = div_quo;
                DIV_JUMP: begin
                    frame_nxt_next = div_rem[7:0];
                    row_nxt_next   = (kind_reg == EFF_SKIP) ? val_reg : 8'd0;
                    js_next        = 1'b1;
                end
            endcase
        end
    end

    // result register, parts the output side from the sequencing
    always_comb begin
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
            mdata_next  = {6'd0, speed_reg, tempo_reg, halt_reg, row_now_reg,
                           frame_now_reg, begin_reg};
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            song_tempo_reg <= RST_SONG_TEMPO;
            song_speed_reg <= RST_SONG_SPEED;
            frame_rate_reg <= RST_FRAME_RATE;
            rows_cfg_reg   <= RST_ROWS;
            frames_cfg_reg <= RST_FRAMES;
            split_reg      <= RST_SPEED_SPLIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SONG_TEMPO:  song_tempo_reg <= cfg_wr_data[7:0];
                CFG_SONG_SPEED:  song_speed_reg <= cfg_wr_data[7:0];
                CFG_FRAME_RATE:  frame_rate_reg <= cfg_wr_data[7:0];
                CFG_ROWS:        rows_cfg_reg   <= cfg_wr_data;
                CFG_FRAMES:      frames_cfg_reg <= cfg_wr_data;
                CFG_SPEED_SPLIT: split_reg      <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            dec_reg       <= '0;
            tempo_reg     <= RST_SONG_TEMPO;
            speed_reg     <= RST_SONG_SPEED;
            frame_now_reg <= '0;
            row_now_reg   <= '0;
            frame_nxt_reg <= '0;
            row_nxt_reg   <= '0;
            halt_reg      <= 1'b1;
            js_reg        <= 1'b0;
            fjs_reg       <= 1'b0;
            open_reg      <= 1'b0;
            begin_reg     <= 1'b0;
            mvalid_reg    <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            dec_reg       <= dec_next;
            tempo_reg     <= tempo_next;
            speed_reg     <= speed_next;
            frame_now_reg <= frame_now_next;
            row_now_reg   <= row_now_next;
            frame_nxt_reg <= frame_nxt_next;
            row_nxt_reg   <= row_nxt_next;
            halt_reg      <= halt_next;
            js_reg        <= js_next;
            fjs_reg       <= fjs_next;
            open_reg      <= open_next;
            begin_reg     <= begin_next;
            mvalid_reg    <= mvalid_next;
        end
        act_reg   <= act_next;
        kind_reg  <= kind_next;
        val_reg   <= val_next;
        sf_reg    <= sf_next;
        sr_reg    <= sr_next;
        mdata_reg <= mdata_next;
    end

    assign stat.action          = act_reg;
    assign stat.kind            = kind_reg;
    assign stat.row_open        = open_reg;
    assign stat.frame_jump_seen = fjs_reg;
    // the jump would land where the pending position already is
    assign stat.goto_same       = (target == {1'b0, frame_nxt_reg}) && (row_nxt_reg == 8'd0);
    assign stat.div_done        = div_done;
    assign stat.out_free        = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ===== sv/trs_ctrl.sv =====
module trs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  trs_pkg::stat_t stat,
    output trs_pkg::cmd_t  cmd
);
    import trs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;
    logic     need_div;
    div_sel_t first_sel;

    // which division, if any, follows the update in the exec state
    always_comb begin
        need_div  = 1'b0;
        first_sel = DIV_DEC;
        if (stat.action == ACT_START) begin
            need_div  = 1'b1;
            first_sel = DIV_FMOD_START;
        end else if (stat.action == ACT_EFFECT && stat.row_open) begin
            if (stat.kind == EFF_SPEED) begin
                need_div = 1'b1;
            end else if (stat.kind == EFF_JUMP && !stat.goto_same) begin
                need_div  = 1'b1;
                first_sel = DIV_JUMP;
            end else if (stat.kind == EFF_SKIP && !stat.frame_jump_seen && !stat.goto_same) begin
                need_div  = 1'b1;
                first_sel = DIV_JUMP;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_wb    = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.sel       = sel_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (need_div) begin
                    sel_next   = first_sel;
                    state_next = ST_DIV_GO;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.div_wb = 1'b1;
                    // start chains frame, row and decrement
                    unique case (sel_reg)
                        DIV_FMOD_START: begin
                            sel_next   = DIV_RMOD_START;
                            state_next = ST_DIV_GO;
                        end
                        DIV_RMOD_START: begin
                            sel_next   = DIV_DEC;
                            state_next = ST_DIV_GO;
                        end
                        DIV_DEC, DIV_JUMP: state_next = ST_OUT;
                    endcase
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_DEC;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ===== sv/tracker_row_sequencer_unit.sv =====
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+----------------------------------------------
// s_        | in        | s_tvalid/s_tready  | s_tuser: action; s_tdata: kind, value, frame, row
// m_        | out       | m_tvalid/m_tready  | m_tdata: begin, frame, row, stopped, tempo, speed
// cfg_      | in        | cfg_wr_en          | cfg_addr, cfg_wr_data
//
// one item at a time; s_tready is high only while the sequencer waits for input
// tick, row end and plain effects: item latched, then executed, then result loaded; no division
// speed effects, taken jumps and skips: a 13-step division between execution and result load
// start: three divisions in turn on the shared divider, then the result load
// a result waiting on m_tready holds the next item at its last step only
// synchronous active-low reset: halted, tempo 150, speed 6, position zero
module tracker_row_sequencer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [trs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [trs_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trs_pkg::S_DATA_W-1:0]   s_tdata,  // effect_kind, effect_value, start_frame, start_row
    input  logic [trs_pkg::S_USER_W-1:0]   s_tuser,  // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [trs_pkg::M_DATA_W-1:0]   m_tdata   // row_begin, play_frame, play_row, stopped,
                                                      // cur_tempo, cur_speed
);
    import trs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    trs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    trs_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // one item in flight: no second accept right after the first
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // tempo and speed in force are never zero
    a_nonzero_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:18] != 8'd0) && (m_tdata[33:26] != 8'd0))
        else $error("zero tempo or speed reported");

    // a row only opens while playing
    a_begin_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[17])
        else $error("row opened while halted");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import trs_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;
    localparam int SEC_PER_MIN   = 60;
    localparam int TEMPO_SCALE   = 24;

    // register settings used by the random phases
    localparam int SET_WIDE       = 0;
    localparam int SET_NARROW     = 1;
    localparam int SET_DEGENERATE = 2;
    localparam int SET_OVERSIZE   = 3;
    localparam int SET_MIXED      = 4;

    // m_tdata[33:0] seen as fields, lowest bit last
    typedef struct packed {
        logic [7:0] speed;
        logic [7:0] tempo;
        logic       stopped;
        logic [7:0] row;
        logic [7:0] frame;
        logic       row_begin;
    } position_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;  // effect_kind, effect_value, start_frame, start_row
    logic [S_USER_W-1:0]   s_tuser = '0;  // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;      // row_begin, play_frame, play_row, stopped,
                                         // cur_tempo, cur_speed

    tracker_row_sequencer_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // register copies
    logic [7:0] song_tempo_r  = RST_SONG_TEMPO;
    logic [7:0] song_speed_r  = RST_SONG_SPEED;
    logic [7:0] frame_rate_r  = RST_FRAME_RATE;
    logic [8:0] rows_r        = RST_ROWS;
    logic [8:0] frames_r      = RST_FRAMES;
    logic [7:0] speed_split_r = RST_SPEED_SPLIT;

    // predicted sequencer state
    int         tempo_acc        = 0;
    int         row_decrement    = 0;
    logic [7:0] tempo_now        = RST_SONG_TEMPO;
    logic [7:0] speed_now        = RST_SONG_SPEED;
    logic [7:0] cur_frame        = '0;
    logic [7:0] cur_row          = '0;
    logic [7:0] next_frame       = '0;
    logic [7:0] next_row         = '0;
    logic       halted           = 1'b1;
    logic       jump_taken       = 1'b0;
    logic       frame_jump_taken = 1'b0;
    logic       row_live         = 1'b0;

    position_t pending_positions[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int cycles    = 0;
    int errors    = 0;

    position_t got_pos;
    position_t want_pos;

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [2:0] rnd3();
        return 3'($urandom_range(7));
    endfunction

    function automatic int wrap_count(input logic [8:0] c, input int maxv);
        if (c == 9'd0) begin
            return 1;
        end
        if (int'(c) > maxv) begin
            return maxv;
        end
        return int'(c);
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    task automatic refresh_decrement();
        int spd;
        spd = (speed_now == 8'd0) ? 1 : int'(speed_now);
        row_decrement = (int'(tempo_now) * TEMPO_SCALE) / spd;
    endtask

    task automatic jump_to(input int f);
        if (int'(next_frame) == f && next_row == 8'd0) begin
            return;
        end
        next_frame = 8'(f % wrap_count(frames_r, MAX_FRAMES));
        next_row   = 8'd0;
        jump_taken = 1'b1;
    endtask

    task automatic take_effect(input logic [2:0] kind, input logic [7:0] val);
        logic [7:0] v;
        v = val;
        case (kind)
            EFF_SPEED: begin
                if (v == 8'd0) begin
                    v = 8'd1;
                end
                if (v > speed_split_r) begin
                    tempo_now = v;
                end else begin
                    speed_now = v;
                end
                refresh_decrement();
            end
            EFF_JUMP: begin
                frame_jump_taken = 1'b1;
                jump_to(int'(val));
            end
            EFF_SKIP: begin
                if (!frame_jump_taken) begin
                    jump_to(int'(cur_frame) + 1);
                    next_row = val;
                end
            end
            EFF_HALT: begin
                halted = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // advance the predicted song position by one accepted item
    task automatic sequencer_step(input logic [1:0] act, input logic [2:0] kind,
                                  input logic [7:0] val, input logic [7:0] sf,
                                  input logic [7:0] sr, output position_t pos);
        int r;
        int f;
        pos.row_begin = 1'b0;
        case (act)
            ACT_TICK: begin
                if (!halted && !row_live) begin
                    if (tempo_acc <= 0) begin
                        tempo_acc = clamp16(tempo_acc + SEC_PER_MIN * int'(frame_rate_r));
                        jump_taken       = 1'b0;
                        frame_jump_taken = 1'b0;
                        cur_frame        = next_frame;
                        cur_row          = next_row;
                        row_live         = 1'b1;
                        pos.row_begin    = 1'b1;
                    end else begin
                        tempo_acc = clamp16(tempo_acc - row_decrement);
                    end
                end
            end
            ACT_START: begin
                cur_frame  = 8'(int'(sf) % wrap_count(frames_r, MAX_FRAMES));
                cur_row    = 8'(int'(sr) % wrap_count(rows_r, MAX_ROWS));
                next_frame = cur_frame;
                next_row   = cur_row;
                tempo_now  = (song_tempo_r == 8'd0) ? 8'd1 : song_tempo_r;
                speed_now  = (song_speed_r == 8'd0) ? 8'd1 : song_speed_r;
                tempo_acc  = 0;
                refresh_decrement();
                halted           = 1'b0;
                jump_taken       = 1'b0;
                frame_jump_taken = 1'b0;
                row_live         = 1'b0;
            end
            ACT_EFFECT: begin
                if (row_live) begin
                    take_effect(kind, val);
                end
            end
            default: begin
                if (row_live) begin
                    row_live = 1'b0;
                    if (!jump_taken) begin
                        r = int'(next_row) + 1;
                        if (r >= wrap_count(rows_r, MAX_ROWS)) begin
                            f = int'(next_frame) + 1;
                            r = 0;
                            if (f >= wrap_count(frames_r, MAX_FRAMES)) begin
                                f = 0;
                            end
                            next_frame = 8'(f);
                        end
                        next_row = 8'(r);
                    end
                    tempo_acc = clamp16(tempo_acc - row_decrement);
                end
            end
        endcase
        pos.frame   = cur_frame;
        pos.row     = cur_row;
        pos.stopped = halted;
        pos.tempo   = tempo_now;
        pos.speed   = speed_now;
    endtask

    task automatic send_item(input logic [1:0] act, input logic [2:0] kind,
                             input logic [7:0] val, input logic [7:0] sf,
                             input logic [7:0] sr);
        position_t pos;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, sr, sf, val, kind};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sequencer_step(act, kind, val, sf, sr, pos);
        pending_positions.push_back(pos);
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, rnd3(), rnd8(), rnd8(), rnd8());
    endtask

    task automatic send_effect(input logic [2:0] kind, input logic [7:0] val);
        send_item(ACT_EFFECT, kind, val, rnd8(), rnd8());
    endtask

    task automatic send_row_end();
        send_item(ACT_ROW_END, rnd3(), rnd8(), rnd8(), rnd8());
    endtask

    task automatic tick_until_row();
        while (!row_live && !halted) begin
            send_tick();
        end
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // call only on a falling edge with the block idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [8:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            CFG_SONG_TEMPO:  song_tempo_r  = val[7:0];
            CFG_SONG_SPEED:  song_speed_r  = val[7:0];
            CFG_FRAME_RATE:  frame_rate_r  = val[7:0];
            CFG_ROWS:        rows_r        = val;
            CFG_FRAMES:      frames_r      = val;
            CFG_SPEED_SPLIT: speed_split_r = val[7:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_setting(input int which);
        case (which)
            SET_WIDE: begin
                write_reg(CFG_SONG_TEMPO, 9'd255);
                write_reg(CFG_SONG_SPEED, 9'd1);
                write_reg(CFG_FRAME_RATE, 9'd255);
                write_reg(CFG_ROWS, 9'd256);
                write_reg(CFG_FRAMES, 9'd256);
                write_reg(CFG_SPEED_SPLIT, 9'd255);
            end
            SET_NARROW: begin
                write_reg(CFG_SONG_TEMPO, 9'd1);
                write_reg(CFG_SONG_SPEED, 9'd1);
                write_reg(CFG_FRAME_RATE, 9'd1);
                write_reg(CFG_ROWS, 9'd1);
                write_reg(CFG_FRAMES, 9'd1);
                write_reg(CFG_SPEED_SPLIT, 9'd0);
            end
            SET_DEGENERATE: begin
                // zero tempo, speed and counts all count as one
                write_reg(CFG_SONG_TEMPO, 9'd0);
                write_reg(CFG_SONG_SPEED, 9'd0);
                write_reg(CFG_FRAME_RATE, 9'd2);
                write_reg(CFG_ROWS, 9'd0);
                write_reg(CFG_FRAMES, 9'd0);
                write_reg(CFG_SPEED_SPLIT, 9'd128);
            end
            SET_OVERSIZE: begin
                write_reg(CFG_SONG_TEMPO, 9'd200);
                write_reg(CFG_SONG_SPEED, 9'd8);
                write_reg(CFG_FRAME_RATE, 9'd20);
                write_reg(CFG_ROWS, 9'd511);
                write_reg(CFG_FRAMES, 9'd300);
                write_reg(CFG_SPEED_SPLIT, 9'($urandom_range(255)));
            end
            default: begin
                write_reg(CFG_SONG_TEMPO, 9'($urandom_range(1, 255)));
                write_reg(CFG_SONG_SPEED, 9'($urandom_range(1, 255)));
                write_reg(CFG_FRAME_RATE, 9'($urandom_range(1, 40)));
                write_reg(CFG_ROWS, 9'($urandom_range(1, 256)));
                write_reg(CFG_FRAMES, 9'($urandom_range(1, 256)));
                write_reg(CFG_SPEED_SPLIT, 9'($urandom_range(255)));
            end
        endcase
    endtask

    // mostly well-formed rows: open with ticks, a few effects, close with row end
    task automatic play_items(input int n);
        int i;
        int pick;
        int roll;
        logic [2:0] kind;
        logic [7:0] val;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (halted || pick < ((row_decrement < 100) ? 10 : 2)) begin
                send_item(ACT_START, rnd3(), rnd8(), rnd8(), rnd8());
            end else if (!row_live) begin
                if (pick < 92) begin
                    send_tick();
                end else begin
                    send_item($urandom_range(1) ? ACT_EFFECT : ACT_ROW_END,
                              rnd3(), rnd8(), rnd8(), rnd8());
                end
            end else if (pick < 52) begin
                roll = $urandom_range(99);
                val  = rnd8();
                if (roll < 30) begin
                    kind = EFF_SPEED;
                    if (roll < 6) begin
                        val = 8'd0;
                    end
                end else if (roll < 52) begin
                    kind = EFF_JUMP;
                    if (roll < 40) begin
                        val = next_frame;
                    end
                end else if (roll < 78) begin
                    kind = EFF_SKIP;
                end else if (roll < 82) begin
                    kind = EFF_HALT;
                end else if (roll < 92) begin
                    kind = EFF_NONE;
                end else begin
                    kind = 3'($urandom_range(int'(EFF_HALT) + 1, 7));
                end
                send_effect(kind, val);
            end else if (pick < 92) begin
                send_row_end();
            end else if (pick < 97) begin
                send_tick();
            end else begin
                send_item(ACT_START, rnd3(), rnd8(), rnd8(), rnd8());
            end
            if (i == n / 2) begin
                wait_results();
            end
        end
    endtask

    task automatic test_halted_after_reset();
        send_tick();
        send_effect(EFF_SPEED, 8'd9);
        send_row_end();
    endtask

    task automatic test_start_and_wrap();
        int k;
        settle();
        write_reg(CFG_FRAME_RATE, 9'd1);
        write_reg(CFG_ROWS, 9'd4);
        write_reg(CFG_FRAMES, 9'd4);
        send_item(ACT_START, EFF_NONE, 8'd0, 8'd255, 8'd255);
        send_tick();
        send_effect(EFF_SPEED, 8'd0);
        send_effect(EFF_SPEED, 8'd200);
        send_effect(EFF_SPEED, 8'd32);
        send_effect(EFF_NONE, 8'd77);
        for (k = int'(EFF_HALT) + 1; k < 8; k++) begin
            send_effect(3'(k), 8'd1);
        end
        send_tick();
        send_row_end();
        tick_until_row();
    endtask

    task automatic test_jumps_and_skips();
        send_effect(EFF_JUMP, 8'd6);
        send_effect(EFF_JUMP, 8'd2);
        send_effect(EFF_SKIP, 8'd1);
        send_row_end();
        tick_until_row();
        // skip to a row past the pattern end, wraps at the following row end
        send_effect(EFF_SKIP, 8'd255);
        send_row_end();
        tick_until_row();
        send_row_end();
        tick_until_row();
    endtask

    task automatic test_halt_and_restart();
        send_effect(EFF_HALT, 8'd0);
        send_row_end();
        send_tick();
        send_item(ACT_START, EFF_NONE, 8'd0, 8'd0, 8'd0);
        send_tick();
        send_item(ACT_START, EFF_NONE, 8'd0, 8'd1, 8'd2);
        send_tick();
    endtask

    task automatic test_random_play(input int idle, input int stall, input int which,
                                    input int n);
        settle();
        load_setting(which);
        idle_pct  = idle;
        stall_pct = stall;
        play_items(n);
    endtask

    task automatic test_backpressure();
        settle();
        load_setting(SET_MIXED);
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 400;
        play_items(40);
    endtask

    // result sink: random stalls plus an optional long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got_pos = m_tdata[33:0];
            if (pending_positions.size() == 0) begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected item: %h", got_pos);
                end
            end else begin
                want_pos = pending_positions.pop_front();
                if (got_pos.row_begin !== want_pos.row_begin ||
                    got_pos.frame !== want_pos.frame ||
                    got_pos.row !== want_pos.row ||
                    got_pos.stopped !== want_pos.stopped ||
                    got_pos.tempo !== want_pos.tempo ||
                    got_pos.speed !== want_pos.speed) begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: begin %0d/%0d frame %0d/%0d row %0d/%0d",
                                 want_pos.row_begin, got_pos.row_begin,
                                 want_pos.frame, got_pos.frame,
                                 want_pos.row, got_pos.row);
                        $display("          stopped %0d/%0d tempo %0d/%0d speed %0d/%0d",
                                 want_pos.stopped, got_pos.stopped,
                                 want_pos.tempo, got_pos.tempo,
                                 want_pos.speed, got_pos.speed);
                    end
                end
            end
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_halted_after_reset();
        test_start_and_wrap();
        test_jumps_and_skips();
        test_halt_and_restart();
        test_random_play(0, 0, SET_WIDE, 470);
        test_random_play(63, 0, SET_NARROW, 470);
        test_random_play(0, 63, SET_DEGENERATE, 470);
        test_random_play(26, 26, SET_OVERSIZE, 470);
        test_backpressure();
        settle();
        if (errors == 0 && pending_positions.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/trs_pkg.sv
sv/trs_div.sv
sv/trs_dp.sv
sv/trs_ctrl.sv
sv/tracker_row_sequencer_unit.sv
tb/tb.sv
